FILE: src/bbal_pkg.sv
// Shared constants, types and index helpers for the buddy block allocator.
package bbal_pkg;

	// Arena and tree geometry
	localparam int LEAF_ORDER  = 4;
	localparam int ARENA_ORDER = 10;
	localparam int LEVELS      = ARENA_ORDER - LEAF_ORDER;
	localparam int NODES       = (2 << LEVELS) - 1;
	localparam int NODE_W      = $clog2(NODES + 1);
	localparam int NODE_XW     = NODE_W + 1;
	localparam int DEPTH_W     = $clog2(LEVELS + 2);
	localparam int ADDR_W      = ARENA_ORDER;
	localparam int REQ_W       = ARENA_ORDER + 1;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = ((REQ_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;

	// Request kind carried in s_tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	typedef logic [NODE_W-1:0]  node_idx_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [REQ_W-1:0]   req_t;

	// Per-node state; a split node has both bits clear
	typedef struct packed {
		logic is_used;
		logic is_free;
	} node_st_t;

	localparam int NODE_ST_W = $bits(node_st_t);
	localparam node_st_t NODE_SPLIT = '{is_used: 1'b0, is_free: 1'b0};
	localparam node_st_t NODE_FREE  = '{is_used: 1'b0, is_free: 1'b1};
	localparam node_st_t NODE_USED  = '{is_used: 1'b1, is_free: 1'b0};

	// Node store access, one read and one write per cycle
	typedef struct packed {
		logic      re;
		node_idx_t raddr;
		logic      we;
		node_idx_t waddr;
		node_st_t  wdata;
	} mem_req_t;

	typedef struct packed {
		status_t status;
		addr_t   addr;
	} result_t;

	typedef struct packed {
		logic   too_big;
		depth_t depth;
	} depth_res_t;

	// Block size in bytes at tree depth d
	function automatic req_t blk_size(input depth_t d);
		blk_size = REQ_W'(1) << (ARENA_ORDER - int'(d));
	endfunction

	// First and last node index at depth d
	function automatic node_idx_t level_first(input depth_t d);
		logic [NODE_XW-1:0] t;
		t = (NODE_XW'(1) << d) - NODE_XW'(1);
		return t[NODE_W-1:0];
	endfunction

	function automatic node_idx_t level_last(input depth_t d);
		logic [NODE_XW-1:0] t;
		t = (NODE_XW'(2) << d) - NODE_XW'(2);
		return t[NODE_W-1:0];
	endfunction

	// Deepest level whose block still holds req bytes
	function automatic depth_res_t depth_for(input req_t req);
		depth_res_t r;
		r.too_big = 1'b1;
		r.depth   = '0;
		for (int d = 0; d <= LEVELS; d++) begin
			if (blk_size(DEPTH_W'(d)) >= req) begin
				r.too_big = 1'b0;
				r.depth   = DEPTH_W'(d);
			end
		end
		return r;
	endfunction

	// Node holding byte offset a at depth d
	function automatic node_idx_t node_of(input depth_t d, input addr_t a);
		addr_t k;
		k = a >> (ARENA_ORDER - int'(d));
		return level_first(d) + NODE_W'(k);
	endfunction

endpackage

FILE: src/bbal_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bbal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/bbal_node_store.sv
// Node state store: RAM plus per-node valid bits that supply the reset state.
module bbal_node_store (
	input  logic                clk,
	input  logic                arst_n,
	input  bbal_pkg::mem_req_t  req,
	output bbal_pkg::node_st_t  rd_state
);

	logic [bbal_pkg::NODES-1:0]     vld_q;
	logic                           rd_vld_q;
	logic                           rd_root_q;
	logic [bbal_pkg::NODE_ST_W-1:0] ram_rdata;

	bbal_ram #(
		.WIDTH(bbal_pkg::NODE_ST_W),
		.DEPTH(bbal_pkg::NODES)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.raddr),
		.rdata (ram_rdata)
	);

	// valid bit per node; unwritten nodes read as reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_root_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q  <= vld_q[req.raddr];
				rd_root_q <= (req.raddr == '0);
			end
		end
	end

	// only the root is free out of reset
	assign rd_state = rd_vld_q ? bbal_pkg::node_st_t'(ram_rdata) :
		(rd_root_q ? bbal_pkg::NODE_FREE : bbal_pkg::NODE_SPLIT);

endmodule

FILE: src/bbal_seq.sv
// Request sequencer: level scan, split and merge walks over the node store.
module bbal_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_mode,
	input  bbal_pkg::req_t      in_req,
	input  bbal_pkg::addr_t     in_addr,
	output logic                res_valid,
	input  logic                res_ready,
	output bbal_pkg::result_t   res,
	output bbal_pkg::mem_req_t  mreq,
	input  bbal_pkg::node_st_t  rd_state
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_TAKE  = 9'b000000100,
		S_SPLIT = 9'b000001000,
		S_FCHK  = 9'b000010000,
		S_FEVAL = 9'b000100000,
		S_MEVAL = 9'b001000000,
		S_FEND  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t                state_q;
	bbal_pkg::depth_t      d_q;
	bbal_pkg::addr_t       a_q;
	bbal_pkg::node_idx_t   cur_q;
	bbal_pkg::depth_t      lvl_q;
	bbal_pkg::addr_t       off_q;
	bbal_pkg::node_idx_t   scan_idx_q;
	bbal_pkg::depth_t      scan_lvl_q;
	logic                  scan_more_q;
	logic                  pend_q;
	bbal_pkg::node_idx_t   pend_idx_q;
	bbal_pkg::depth_t      pend_lvl_q;
	bbal_pkg::result_t     res_q;

	bbal_pkg::depth_res_t  dr;
	logic                  misaligned;
	logic                  found;
	bbal_pkg::depth_t      lvl_nxt;
	bbal_pkg::node_idx_t   parent_cur;

	// tree index helpers
	function automatic bbal_pkg::node_idx_t left_child(input bbal_pkg::node_idx_t n);
		return {n[bbal_pkg::NODE_W-2:0], 1'b1};
	endfunction

	function automatic bbal_pkg::node_idx_t right_child(input bbal_pkg::node_idx_t n);
		bbal_pkg::node_idx_t np1;
		np1 = n + bbal_pkg::NODE_W'(1);
		return {np1[bbal_pkg::NODE_W-2:0], 1'b0};
	endfunction

	function automatic bbal_pkg::node_idx_t parent_of(input bbal_pkg::node_idx_t n);
		bbal_pkg::node_idx_t nm1;
		nm1 = n - bbal_pkg::NODE_W'(1);
		return {1'b0, nm1[bbal_pkg::NODE_W-1:1]};
	endfunction

	function automatic bbal_pkg::node_idx_t buddy_of(input bbal_pkg::node_idx_t n);
		return n[0] ? (n + bbal_pkg::NODE_W'(1)) : (n - bbal_pkg::NODE_W'(1));
	endfunction

	// request decode
	always_comb begin
		dr         = bbal_pkg::depth_for(in_req);
		misaligned = (in_addr & bbal_pkg::ADDR_W'(bbal_pkg::blk_size(dr.depth) -
			bbal_pkg::REQ_W'(1))) != '0;
	end

	assign found      = pend_q && rd_state.is_free;
	assign lvl_nxt    = lvl_q + bbal_pkg::DEPTH_W'(1);
	assign parent_cur = parent_of(cur_q);
	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res        = res_q;

	// node store accesses per state
	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE, S_DONE: begin
			end
			S_SCAN: begin
				if (!found && scan_more_q) begin
					mreq.re    = 1'b1;
					mreq.raddr = scan_idx_q;
				end
			end
			S_TAKE: begin
				mreq.we    = 1'b1;
				mreq.waddr = cur_q;
				mreq.wdata = (lvl_q == d_q) ? bbal_pkg::NODE_USED : bbal_pkg::NODE_SPLIT;
			end
			S_SPLIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = left_child(cur_q);
				mreq.wdata = bbal_pkg::NODE_FREE;
			end
			S_FCHK: begin
				mreq.re    = 1'b1;
				mreq.raddr = cur_q;
			end
			S_FEVAL: begin
				if (rd_state.is_used) begin
					mreq.we    = 1'b1;
					mreq.waddr = cur_q;
					mreq.wdata = bbal_pkg::NODE_SPLIT;
					if (cur_q != '0) begin
						mreq.re    = 1'b1;
						mreq.raddr = buddy_of(cur_q);
					end
				end
			end
			S_MEVAL: begin
				if (rd_state.is_free) begin
					mreq.we    = 1'b1;
					mreq.waddr = buddy_of(cur_q);
					mreq.wdata = bbal_pkg::NODE_SPLIT;
					if (parent_cur != '0) begin
						mreq.re    = 1'b1;
						mreq.raddr = buddy_of(parent_cur);
					end
				end
			end
			S_FEND: begin
				mreq.we    = 1'b1;
				mreq.waddr = cur_q;
				mreq.wdata = bbal_pkg::NODE_FREE;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_more_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						d_q <= dr.depth;
						a_q <= in_addr;
						if (in_mode == bbal_pkg::MODE_ALLOC) begin
							if (dr.too_big) begin
								res_q   <= '{status: bbal_pkg::ST_NOSPACE, addr: '0};
								state_q <= S_DONE;
							end else begin
								scan_lvl_q  <= dr.depth;
								scan_idx_q  <= bbal_pkg::level_first(dr.depth);
								scan_more_q <= 1'b1;
								pend_q      <= 1'b0;
								state_q     <= S_SCAN;
							end
						end else begin
							// an arena-sized address field cannot point past the arena
							if (dr.too_big || misaligned) begin
								res_q   <= '{status: bbal_pkg::ST_BADFREE, addr: '0};
								state_q <= S_DONE;
							end else begin
								cur_q   <= bbal_pkg::node_of(dr.depth, in_addr);
								state_q <= S_FCHK;
							end
						end
					end
				end

				// one read per cycle, smallest fitting level first, lowest address first
				S_SCAN: begin
					if (found) begin
						cur_q   <= pend_idx_q;
						lvl_q   <= pend_lvl_q;
						off_q   <= bbal_pkg::ADDR_W'(pend_idx_q -
							bbal_pkg::level_first(pend_lvl_q)) <<
							(bbal_pkg::ARENA_ORDER - int'(pend_lvl_q));
						state_q <= S_TAKE;
					end else if (scan_more_q) begin
						pend_q     <= 1'b1;
						pend_idx_q <= scan_idx_q;
						pend_lvl_q <= scan_lvl_q;
						if (scan_idx_q == bbal_pkg::level_last(scan_lvl_q)) begin
							if (scan_lvl_q == '0) begin
								scan_more_q <= 1'b0;
							end else begin
								scan_lvl_q <= scan_lvl_q - bbal_pkg::DEPTH_W'(1);
								scan_idx_q <= bbal_pkg::level_first(scan_lvl_q -
									bbal_pkg::DEPTH_W'(1));
							end
						end else begin
							scan_idx_q <= scan_idx_q + bbal_pkg::NODE_W'(1);
						end
					end else begin
						res_q   <= '{status: bbal_pkg::ST_NOSPACE, addr: '0};
						state_q <= S_DONE;
					end
				end

				// grant at target depth, otherwise mark split and descend
				S_TAKE: begin
					if (lvl_q == d_q) begin
						res_q   <= '{status: bbal_pkg::ST_OK, addr: off_q};
						state_q <= S_DONE;
					end else begin
						state_q <= S_SPLIT;
					end
				end

				// lower half stays free, walk into the upper half
				S_SPLIT: begin
					cur_q <= right_child(cur_q);
					lvl_q <= lvl_nxt;
					off_q <= off_q + bbal_pkg::ADDR_W'(bbal_pkg::blk_size(lvl_nxt));
					if (lvl_nxt == d_q) begin
						state_q <= S_TAKE;
					end
				end

				S_FCHK: begin
					state_q <= S_FEVAL;
				end

				// block must be granted at exactly this size
				S_FEVAL: begin
					if (!rd_state.is_used) begin
						res_q   <= '{status: bbal_pkg::ST_BADFREE, addr: '0};
						state_q <= S_DONE;
					end else if (cur_q == '0) begin
						state_q <= S_FEND;
					end else begin
						state_q <= S_MEVAL;
					end
				end

				// merge with free buddy, one level per cycle
				S_MEVAL: begin
					if (rd_state.is_free) begin
						cur_q <= parent_cur;
						if (parent_cur == '0) begin
							state_q <= S_FEND;
						end
					end else begin
						state_q <= S_FEND;
					end
				end

				S_FEND: begin
					res_q   <= '{status: bbal_pkg::ST_OK, addr: a_q};
					state_q <= S_DONE;
				end

				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/buddy_block_allocator.sv
// Buddy block allocator: top level with stream ports and output register.
//
// One request beat on the s_ side (s_tuser = allocate or free, s_tdata =
// size and address) yields exactly one result beat on the m_ side
// (m_tdata = granted address and status). Requests are handled one at a
// time: s_tready is high only while the sequencer is idle.
// Steps per request kind:
//   allocate: one node read per cycle, smallest fitting level first and
//     lowest address first; a larger free block is marked split and
//     walked down level by level, the lower half left free, to the target
//     depth; out of space when no node at or above that level is free.
//   free: the block must be granted at exactly this size; it then merges
//     with free buddies level by level, at most up to the root.
//   too large or misaligned: rejected without a node store access. The
//     node store's single read port sets the pace of these steps.
// Results sit in an output register, so a new request is taken while a
// result waits; when the receiver stalls with that register full, the next
// result waits in the sequencer and s_tready stays low.
// Reset (arst_n low) empties the arena to a single free block; no clearing
// pass is needed, per-node valid bits supply the reset state.
module buddy_block_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [10:0] request_size, [20:11] block_address, rest zero
	input  logic [bbal_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] mode
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [9:0] granted_address, [11:10] status, rest zero
	output logic [bbal_pkg::OUT_TDATA_W-1:0] m_tdata
);

	bbal_pkg::mem_req_t  mreq;
	bbal_pkg::node_st_t  rd_state;
	bbal_pkg::result_t   res;
	bbal_pkg::result_t   out_q;
	logic                res_valid;
	logic                res_ready;
	logic                out_valid_q;

	bbal_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser[0]),
		.in_req    (s_tdata[bbal_pkg::REQ_W-1:0]),
		.in_addr   (s_tdata[bbal_pkg::REQ_W +: bbal_pkg::ADDR_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mreq      (mreq),
		.rd_state  (rd_state)
	);

	bbal_node_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.rd_state (rd_state)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = bbal_pkg::OUT_TDATA_W'(out_q);

endmodule

FILE: src/bbal_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
module bbal_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bbal_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [bbal_pkg::STATUS_W-1:0] st;
	logic [bbal_pkg::ADDR_W-1:0]   adr;

	assign st  = m_tdata[bbal_pkg::ADDR_W +: bbal_pkg::STATUS_W];
	assign adr = m_tdata[bbal_pkg::ADDR_W-1:0];

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == bbal_pkg::ST_OK || st == bbal_pkg::ST_NOSPACE ||
			st == bbal_pkg::ST_BADFREE))
		else $error("undefined status code");

	// an error result carries address zero
	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != bbal_pkg::ST_OK |-> adr == '0)
		else $error("error result with nonzero address");

	// one request in flight: no back-to-back accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

endmodule

bind buddy_block_allocator bbal_checker u_bbal_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
